### rtl/fmtsp_pkg.sv
// Package for the format specifier parser: stage codes, character codes,
// numeric limits and the saturating decimal accumulate.
// No dependencies.
package fmtsp_pkg;

    // Parse stages, one-hot
    typedef enum logic [6:0] {
        ST_ZERO   = 7'b0000001,
        ST_DASH   = 7'b0000010,
        ST_WDIG   = 7'b0000100,
        ST_DOT    = 7'b0001000,
        ST_PFIRST = 7'b0010000,
        ST_PDIG   = 7'b0100000,
        ST_TYPE   = 7'b1000000
    } stage_t;

    // Pad mode codes
    typedef logic [1:0] pad_t;
    localparam pad_t PAD_NONE = 2'd0;
    localparam pad_t PAD_ZERO = 2'd1;
    localparam pad_t PAD_LEFT = 2'd2;

    // Character codes
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE = 8'h39;  // '9'
    localparam logic [7:0] CH_DASH = 8'h2D;  // '-'
    localparam logic [7:0] CH_PLUS = 8'h2B;  // '+'
    localparam logic [7:0] CH_STAR = 8'h2A;  // '*'
    localparam logic [7:0] CH_DOT  = 8'h2E;  // '.'
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LC_C = 8'h63;  // 'c'
    localparam logic [7:0] CH_LC_S = 8'h73;  // 's'
    localparam logic [7:0] CH_LC_P = 8'h70;  // 'p'
    localparam logic [7:0] CH_LC_D = 8'h64;  // 'd'
    localparam logic [7:0] CH_LC_I = 8'h69;  // 'i'
    localparam logic [7:0] CH_LC_U = 8'h75;  // 'u'
    localparam logic [7:0] CH_LC_X = 8'h78;  // 'x'
    localparam logic [7:0] CH_UC_X = 8'h58;  // 'X'

    // Limits
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Decimal digit test
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Accepted conversion characters, NUL included
    function automatic logic type_ok(input logic [7:0] c);
        return (c == CH_NUL)  || (c == CH_LC_C) || (c == CH_LC_S) ||
               (c == CH_LC_P) || (c == CH_LC_D) || (c == CH_LC_I) ||
               (c == CH_LC_U) || (c == CH_LC_X) || (c == CH_UC_X);
    endfunction

    // acc * 10 + digit, saturated at NUM_MAX; times ten as two shifts
    function automatic logic [30:0] accumulate(input logic [30:0] acc,
                                               input logic [3:0]  digit);
        logic [34:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, digit};
        return (sum[34:31] != 4'd0) ? NUM_MAX : sum[30:0];
    endfunction

endpackage

### rtl/format_spec_parser_top.sv
// Format specifier parser top level: input register, stage logic and
// result register. Depends on fmtsp_pkg.

// The parser takes the characters that follow a percent sign, one per
// transfer, together with the variadic int used when the character is '*'.
// It takes one character per clock cycle while the stage logic does not
// hold. A character goes into an input register, is parsed there by the
// stage logic, and the type character's result goes on to the output port
// through the result register. The stage logic only holds when a
// character that ends a specifier meets a full result register that is
// stalled; a character that ends nothing passes on regardless. After a
// result the parser is ready for the next specifier at once.
module format_spec_parser_top
    import fmtsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         spec_char,
    input  logic signed [31:0] star_value,
    // Result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [1:0]         pad_mode,
    output logic [30:0]        field_width,
    output logic signed [31:0] precision_value,
    output logic [7:0]         type_char,
    output logic [15:0]        spec_length
);

    // Input register
    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic [31:0] star_reg;

    // Parse state
    stage_t      stage_reg,  stage_next;
    pad_t        pad_reg,    pad_next;
    logic        err_reg,    err_next;
    logic [30:0] width_reg,  width_next;
    logic [31:0] prec_reg,   prec_next;
    logic [15:0] len_reg,    len_next;

    // Result register
    logic        out_valid_reg;
    logic        res_status_reg;
    pad_t        res_pad_reg;
    logic [30:0] res_width_reg;
    logic [31:0] res_prec_reg;
    logic [7:0]  res_type_reg;
    logic [15:0] res_len_reg;

    // Stage logic outputs
    logic        emit;
    logic        res_status;
    pad_t        res_pad;
    logic [30:0] res_width;
    logic [31:0] res_prec;
    logic [7:0]  res_type;
    logic [15:0] res_len;

    logic        proceed;
    logic        advance;
    logic        in_take;

    // Handshake: the parsed character moves on unless its result would
    // collide with a stalled result
    assign proceed  = !emit || !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && proceed;
    assign in_stall = in_valid_reg && !proceed;
    assign in_take  = in_valid && !in_stall;

    // Stage logic: walk forward through the stages until the character
    // is consumed
    always_comb
    begin
        stage_t      st;
        logic        done;
        logic        bad;
        logic [31:0] neg_star;
        logic [15:0] len_bump;

        st       = stage_reg;
        done     = 1'b0;
        bad      = 1'b0;
        neg_star = 32'd0 - star_reg;
        len_bump = (len_reg == LEN_MAX) ? len_reg : len_reg + 16'd1;

        stage_next = stage_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        width_next = width_reg;
        prec_next  = prec_reg;
        len_next   = len_bump;

        emit       = 1'b0;
        res_status = 1'b0;
        res_pad    = PAD_NONE;
        res_width  = 31'd0;
        res_prec   = 32'd0;
        res_type   = 8'd0;
        res_len    = len_bump;

        // Zero flags
        if (st == ST_ZERO)
        begin
            if (char_reg == CH_ZERO)
            begin
                pad_next   = PAD_ZERO;
                stage_next = ST_ZERO;
                done       = 1'b1;
            end
            else
            begin
                st = ST_DASH;
            end
        end

        // Dash flags, then start of width
        if (!done && st == ST_DASH)
        begin
            if (char_reg == CH_DASH)
            begin
                pad_next   = PAD_LEFT;
                stage_next = ST_DASH;
                done       = 1'b1;
            end
            else if (char_reg == CH_ZERO || char_reg == CH_PLUS)
            begin
                // stray flag: malformed, falls through to the type check
                err_next = 1'b1;
                st       = ST_DOT;
            end
            else if (is_digit(char_reg))
            begin
                width_next = {27'd0, char_reg[3:0]};
                stage_next = ST_WDIG;
                done       = 1'b1;
            end
            else if (char_reg == CH_STAR)
            begin
                if (star_reg[31])
                begin
                    // absolute value; the most negative int saturates
                    width_next = neg_star[31] ? NUM_MAX : neg_star[30:0];
                    if (pad_next == PAD_NONE)
                        pad_next = PAD_LEFT;
                    else
                        err_next = 1'b1;
                end
                else
                begin
                    width_next = star_reg[30:0];
                end
                stage_next = ST_DOT;
                done       = 1'b1;
            end
            else
            begin
                st = ST_DOT;
            end
        end

        // Width digits
        if (!done && st == ST_WDIG)
        begin
            if (is_digit(char_reg))
            begin
                width_next = accumulate(width_reg, char_reg[3:0]);
                stage_next = ST_WDIG;
                done       = 1'b1;
            end
            else
            begin
                st = ST_DOT;
            end
        end

        // Dot
        if (!done && st == ST_DOT)
        begin
            if (char_reg == CH_DOT)
            begin
                prec_next  = 32'd0;
                stage_next = ST_PFIRST;
                done       = 1'b1;
            end
            else
            begin
                st = ST_TYPE;
            end
        end

        // First precision character
        if (!done && st == ST_PFIRST)
        begin
            if (is_digit(char_reg))
            begin
                prec_next  = {28'd0, char_reg[3:0]};
                stage_next = ST_PDIG;
                done       = 1'b1;
            end
            else if (char_reg == CH_STAR)
            begin
                prec_next = star_reg;
                if (star_reg[31])
                    err_next = 1'b1;
                stage_next = ST_TYPE;
                done       = 1'b1;
            end
            else
            begin
                st = ST_TYPE;
            end
        end

        // Precision digits; the value is never negative here
        if (!done && st == ST_PDIG)
        begin
            if (is_digit(char_reg))
            begin
                prec_next  = {1'b0, accumulate(prec_reg[30:0], char_reg[3:0])};
                stage_next = ST_PDIG;
                done       = 1'b1;
            end
            else
            begin
                st = ST_TYPE;
            end
        end

        // Type character, also any unused stage code: emit and restart
        if (!done)
        begin
            bad        = err_next || !type_ok(char_reg);
            emit       = 1'b1;
            res_status = bad;
            res_pad    = bad ? PAD_NONE : pad_next;
            res_width  = bad ? 31'd0 : width_next;
            res_prec   = bad ? 32'd0 : prec_next;
            res_type   = bad ? 8'd0 : char_reg;
            res_len    = len_bump;

            stage_next = ST_ZERO;
            pad_next   = PAD_NONE;
            err_next   = 1'b0;
            width_next = 31'd0;
            prec_next  = '1;
            len_next   = 16'd1;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proceed)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= spec_char;
            star_reg <= star_value;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_ZERO;
            pad_reg   <= PAD_NONE;
            err_reg   <= 1'b0;
            width_reg <= 31'd0;
            prec_reg  <= '1;
            len_reg   <= 16'd1;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
            width_reg <= width_next;
            prec_reg  <= prec_next;
            len_reg   <= len_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_status_reg <= res_status;
            res_pad_reg    <= res_pad;
            res_width_reg  <= res_width;
            res_prec_reg   <= res_prec;
            res_type_reg   <= res_type;
            res_len_reg    <= res_len;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = res_status_reg;
    assign pad_mode        = res_pad_reg;
    assign field_width     = res_width_reg;
    assign precision_value = res_prec_reg;
    assign type_char       = res_type_reg;
    assign spec_length     = res_len_reg;

endmodule
